FILE: rtl/core/hacq_pkg.sv
// ----------------------------------------------------------------------------
// hacq_pkg
// Shared types, constants and the chord lookup for the hit and chord input
// qualifier.
// ----------------------------------------------------------------------------
package hacq_pkg;

  localparam int unsigned HIT_CHANNELS_DEF = 4;
  localparam int unsigned KEY_CHANNELS     = 4;
  localparam int unsigned LEVEL_W          = 4;
  localparam int unsigned CODE_W           = 8;
  localparam int unsigned FAST_W           = 4;
  localparam int unsigned SLOW_W           = 8;
  localparam int unsigned COUNT_W          = 16;
  localparam int unsigned CFG_IDX_W        = 3;
  localparam int unsigned CFG_DATA_W       = 16;

  localparam logic [FAST_W-1:0]  FAST_FILTER_RST  = FAST_W'(2);
  localparam logic [COUNT_W-1:0] HOLD_RELEASE_RST = COUNT_W'(2000);
  localparam logic [COUNT_W-1:0] ERROR_RST        = COUNT_W'(20000);
  localparam logic [SLOW_W-1:0]  SLOW_FILTER_RST  = SLOW_W'(10);
  localparam logic [COUNT_W-1:0] TRIGGER_RST      = COUNT_W'(100);
  localparam logic [COUNT_W-1:0] PRESS_MAX        = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FAST_FILTER  = 3'd0,
    CFG_HOLD_RELEASE = 3'd1,
    CFG_ERROR        = 3'd2,
    CFG_SLOW_FILTER  = 3'd3,
    CFG_TRIGGER      = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [FAST_W-1:0]  fast_filter_ticks;
    logic [COUNT_W-1:0] hold_release_ticks;
    logic [COUNT_W-1:0] error_ticks;
    logic [SLOW_W-1:0]  slow_filter_ticks;
    logic [COUNT_W-1:0] trigger_ticks;
  } cfg_t;

  function automatic logic [CODE_W-1:0] chord_lookup(input logic [KEY_CHANNELS-1:0] mask);
    logic [CODE_W-1:0] code;
    case (mask)
      4'h1:    code = 8'h01;
      4'h2:    code = 8'h02;
      4'h3:    code = 8'h11;
      4'h4:    code = 8'h03;
      4'h6:    code = 8'h12;
      4'h7:    code = 8'h21;
      4'h8:    code = 8'h04;
      4'h9:    code = 8'h1F;
      4'hC:    code = 8'h13;
      4'hE:    code = 8'h21;
      4'hF:    code = 8'h31;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

FILE: rtl/core/hacq_hit_chan.sv
// ----------------------------------------------------------------------------
// hacq_hit_chan
// One hit channel: on/off debounce, hold timer with forced release and
// stuck-active error flag.
// ----------------------------------------------------------------------------
module hacq_hit_chan (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             level_i,
  input  hacq_pkg::cfg_t   cfg_i,
  output logic             hit_o,
  output logic             err_o
);

  logic [hacq_pkg::FAST_W-1:0]  on_q, on_d, off_q, off_d;
  logic [hacq_pkg::COUNT_W-1:0] hold_q, hold_d;
  logic                         hit_q, hit_d, err_q, err_d;

  always_comb begin
    on_d   = on_q;
    off_d  = off_q;
    hold_d = hold_q;
    hit_d  = hit_q;
    err_d  = err_q;
    if (level_i) begin
      off_d = '0;
      if (on_q < cfg_i.fast_filter_ticks) on_d = on_q + 1'b1;
      if (hold_q < cfg_i.error_ticks) hold_d = hold_q + 1'b1;
      if (on_d >= cfg_i.fast_filter_ticks) hit_d = 1'b1;
      if (hold_d >= cfg_i.hold_release_ticks) hit_d = 1'b0;
      if (hold_d >= cfg_i.error_ticks) err_d = 1'b1;
    end else begin
      on_d = '0;
      if (off_q < cfg_i.fast_filter_ticks) off_d = off_q + 1'b1;
      if (off_d >= cfg_i.fast_filter_ticks) begin
        hit_d  = 1'b0;
        err_d  = 1'b0;
        hold_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q   <= '0;
      off_q  <= '0;
      hold_q <= '0;
      hit_q  <= 1'b0;
      err_q  <= 1'b0;
    end else if (step_i) begin
      on_q   <= on_d;
      off_q  <= off_d;
      hold_q <= hold_d;
      hit_q  <= hit_d;
      err_q  <= err_d;
    end
  end

  assign hit_o = hit_q;
  assign err_o = err_q;

endmodule

FILE: rtl/core/hacq_key_chord.sv
// ----------------------------------------------------------------------------
// hacq_key_chord
// Key debounce, press timer and latched chord code.
// ----------------------------------------------------------------------------
module hacq_key_chord (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 step_i,
  input  logic [hacq_pkg::KEY_CHANNELS-1:0]    key_levels_i,
  input  hacq_pkg::cfg_t                       cfg_i,
  output logic [hacq_pkg::CODE_W-1:0]          key_code_o
);

  logic [hacq_pkg::SLOW_W-1:0]       on_q  [hacq_pkg::KEY_CHANNELS];
  logic [hacq_pkg::SLOW_W-1:0]       on_d  [hacq_pkg::KEY_CHANNELS];
  logic [hacq_pkg::SLOW_W-1:0]       off_q [hacq_pkg::KEY_CHANNELS];
  logic [hacq_pkg::SLOW_W-1:0]       off_d [hacq_pkg::KEY_CHANNELS];
  logic [hacq_pkg::KEY_CHANNELS-1:0] keys_q, keys_d;
  logic [hacq_pkg::COUNT_W-1:0]      press_q, press_d;
  logic [hacq_pkg::CODE_W-1:0]       code_q, code_d;

  always_comb begin
    keys_d = keys_q;
    for (int k = 0; k < hacq_pkg::KEY_CHANNELS; k++) begin
      on_d[k]  = on_q[k];
      off_d[k] = off_q[k];
      if (!key_levels_i[k]) begin
        off_d[k] = '0;
        if (on_q[k] < cfg_i.slow_filter_ticks) on_d[k] = on_q[k] + 1'b1;
        if (on_d[k] >= cfg_i.slow_filter_ticks) keys_d[k] = 1'b1;
      end else begin
        on_d[k] = '0;
        if (off_q[k] < cfg_i.slow_filter_ticks) off_d[k] = off_q[k] + 1'b1;
        if (off_d[k] >= cfg_i.slow_filter_ticks) keys_d[k] = 1'b0;
      end
    end
  end

  always_comb begin
    if (keys_d != '0) begin
      press_d = (press_q != hacq_pkg::PRESS_MAX) ? press_q + 1'b1 : press_q;
    end else begin
      press_d = '0;
    end
    code_d = code_q;
    if (code_q != '0) begin
      if (keys_d == '0) code_d = '0;
    end else if (keys_d != '0 && press_d >= cfg_i.trigger_ticks) begin
      code_d = hacq_pkg::chord_lookup(keys_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < hacq_pkg::KEY_CHANNELS; k++) begin
        on_q[k]  <= '0;
        off_q[k] <= '0;
      end
      keys_q  <= '0;
      press_q <= '0;
      code_q  <= '0;
    end else if (step_i) begin
      for (int k = 0; k < hacq_pkg::KEY_CHANNELS; k++) begin
        on_q[k]  <= on_d[k];
        off_q[k] <= off_d[k];
      end
      keys_q  <= keys_d;
      press_q <= press_d;
      code_q  <= code_d;
    end
  end

  assign key_code_o = code_q;

endmodule

FILE: rtl/core/hit_and_chord_input_qualifier.sv
// ----------------------------------------------------------------------------
// hit_and_chord_input_qualifier
// Debounced hit channels with hold timeout and error flags, plus debounced
// keys that latch a chord code.
// ----------------------------------------------------------------------------
// Each accepted transaction is one sampling tick and yields exactly one result
// transaction, showing the state after that tick. The qualifier state itself
// serves as the result register, so a new tick is accepted every cycle as long
// as the previous result is taken in the same cycle or has already left; the
// rate is one tick per clock cycle, set by the single result register.
// Configuration is written through a separate port that is always ready.
module hit_and_chord_input_qualifier #(
  parameter int unsigned HitChannels = hacq_pkg::HIT_CHANNELS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [hacq_pkg::LEVEL_W-1:0]       hit_levels_i,
  input  logic [hacq_pkg::LEVEL_W-1:0]       key_levels_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [hacq_pkg::LEVEL_W-1:0]       hit_bits_o,
  output logic [hacq_pkg::CODE_W-1:0]        key_code_o,
  output logic [hacq_pkg::LEVEL_W-1:0]       error_bits_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [hacq_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [hacq_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  hacq_pkg::cfg_t         cfg_q;
  logic                   out_valid_q, out_valid_d;
  logic                   step;
  logic [HitChannels-1:0] hit_vec, err_vec;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign step        = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fast_filter_ticks  <= hacq_pkg::FAST_FILTER_RST;
      cfg_q.hold_release_ticks <= hacq_pkg::HOLD_RELEASE_RST;
      cfg_q.error_ticks        <= hacq_pkg::ERROR_RST;
      cfg_q.slow_filter_ticks  <= hacq_pkg::SLOW_FILTER_RST;
      cfg_q.trigger_ticks      <= hacq_pkg::TRIGGER_RST;
    end else if (cfg_valid_i) begin
      case (hacq_pkg::cfg_idx_e'(cfg_index_i))
        hacq_pkg::CFG_FAST_FILTER: begin
          cfg_q.fast_filter_ticks <= cfg_data_i[hacq_pkg::FAST_W-1:0];
        end
        hacq_pkg::CFG_HOLD_RELEASE: begin
          cfg_q.hold_release_ticks <= cfg_data_i[hacq_pkg::COUNT_W-1:0];
        end
        hacq_pkg::CFG_ERROR: begin
          cfg_q.error_ticks <= cfg_data_i[hacq_pkg::COUNT_W-1:0];
        end
        hacq_pkg::CFG_SLOW_FILTER: begin
          cfg_q.slow_filter_ticks <= cfg_data_i[hacq_pkg::SLOW_W-1:0];
        end
        hacq_pkg::CFG_TRIGGER: begin
          cfg_q.trigger_ticks <= cfg_data_i[hacq_pkg::COUNT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  for (genvar ch = 0; ch < HitChannels; ch++) begin : g_hit
    logic level;
    if (ch < hacq_pkg::LEVEL_W) begin : g_wired
      assign level = hit_levels_i[ch];
    end else begin : g_idle
      assign level = 1'b0;
    end
    hacq_hit_chan u_chan (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (step),
      .level_i (level),
      .cfg_i   (cfg_q),
      .hit_o   (hit_vec[ch]),
      .err_o   (err_vec[ch])
    );
  end

  for (genvar b = 0; b < hacq_pkg::LEVEL_W; b++) begin : g_out
    if (b < HitChannels) begin : g_used
      assign hit_bits_o[b]   = hit_vec[b];
      assign error_bits_o[b] = err_vec[b];
    end else begin : g_unused
      assign hit_bits_o[b]   = 1'b0;
      assign error_bits_o[b] = 1'b0;
    end
  end

  hacq_key_chord u_keys (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .key_levels_i (key_levels_i),
    .cfg_i        (cfg_q),
    .key_code_o   (key_code_o)
  );

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/core/hacq_checker.sv
// ----------------------------------------------------------------------------
// hacq_checker
// Port-level checks for the hit and chord input qualifier.
// ----------------------------------------------------------------------------
module hacq_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [hacq_pkg::LEVEL_W-1:0]       hit_bits_o,
  input logic [hacq_pkg::CODE_W-1:0]        key_code_o,
  input logic [hacq_pkg::LEVEL_W-1:0]       error_bits_o
);

  // A stalled result transaction keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hit_bits_o)
      && $stable(key_code_o) && $stable(error_bits_o))
    else $error("stalled result changed");

  // Every accepted input transaction produces a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted tick gave no result");

  // Input is only held off while a result is waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no pending result");

  // A latched chord code only ever changes by being released to zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_code_o != '0 |=> key_code_o == $past(key_code_o) || key_code_o == '0)
    else $error("latched chord code changed without release");

endmodule

bind hit_and_chord_input_qualifier hacq_checker u_hacq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .hit_bits_o   (hit_bits_o),
  .key_code_o   (key_code_o),
  .error_bits_o (error_bits_o)
);
